FILE: rtl/gnfp_pkg.sv
// Shared types and constants of the nearest free pixel placer.
package gnfp_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int FRAC_BITS  = 8;

   localparam int WISH_W  = 14;
   localparam int COLOR_W = 8;
   localparam int SLOT_W  = 12;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [CSR_DATA_W-1:0] IMAGE_WIDTH_RESET  = 7'd64;
   localparam logic [CSR_DATA_W-1:0] IMAGE_HEIGHT_RESET = 7'd64;

   typedef struct packed {
      logic               start_image;
      logic [WISH_W-1:0]  wish_x;
      logic [WISH_W-1:0]  wish_y;
      logic [COLOR_W-1:0] red_in;
      logic [COLOR_W-1:0] green_in;
      logic [COLOR_W-1:0] blue_in;
   } req_word_type;

   typedef struct packed {
      logic               placed;
      logic [SLOT_W-1:0]  slot_index;
      logic [COLOR_W-1:0] red_out;
      logic [COLOR_W-1:0] green_out;
      logic [COLOR_W-1:0] blue_out;
   } rsp_word_type;

endpackage

FILE: rtl/gnfp_ram.sv
// Generic single write port RAM with registered read.
module gnfp_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/gnfp_dist.sv
// Pipelined squared distance unit: wished position to one grid slot.
module gnfp_dist
   import gnfp_pkg::*;
#(
   parameter int XW        = 6,
   parameter int YW        = 6,
   parameter int CW        = 14
) (
   input  logic              clock,
   input  logic [WISH_W-1:0] wish_x,
   input  logic [WISH_W-1:0] wish_y,
   input  logic [XW-1:0]     x,
   input  logic [YW-1:0]     y,
   output logic [2*CW:0]     sq_dist
);

   logic [CW-1:0]   wx;
   logic [CW-1:0]   wy;
   logic [CW-1:0]   tx;
   logic [CW-1:0]   ty;
   logic [CW-1:0]   dx_in;
   logic [CW-1:0]   dy_in;
   logic [CW-1:0]   dx_ff;
   logic [CW-1:0]   dy_ff;
   logic [2*CW-1:0] sqx_ff;
   logic [2*CW-1:0] sqy_ff;

   always_comb begin
      wx = CW'(wish_x);
      wy = CW'(wish_y);
      tx = CW'(x) << FRAC_BITS;
      ty = CW'(y) << FRAC_BITS;
      dx_in = (wx >= tx) ? (wx - tx) : (tx - wx);
      dy_in = (wy >= ty) ? (wy - ty) : (ty - wy);
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sqx_ff <= dx_ff * dx_ff;
      sqy_ff <= dy_ff * dy_ff;
   end

   assign sq_dist = {1'b0, sqx_ff} + {1'b0, sqy_ff};

endmodule

FILE: rtl/greedy_nearest_free_pixel_placer_unit.sv
// Top level of the greedy nearest free pixel placer.
//
// The req channel takes one source pixel word: start flag, wished position
// (unsigned fixed point, FRAC_BITS fraction bits) and color. The rsp channel
// returns one word per pixel: placed flag, chosen slot index and color; an
// unplaced pixel returns all zero fields. The csr port writes image width
// (index 0) and image height (index 1); the user must write them only while
// the block is idle, which the block itself does not enforce. An item scans
// every slot of the width by height grid, one slot per cycle through the
// shared distance unit and the occupancy RAM read port, then passes through
// pipeline drain, commit and result load. A word with start_image set first
// runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT slots of the occupancy
// RAM. After reset the same clearing pass runs and req_stall stays high until
// it completes. req_stall is low only while idle. The result sits in an output
// register; the next word is accepted while it waits, and only the final
// result load holds when rsp_stall keeps the previous word in place.
module greedy_nearest_free_pixel_placer_unit
   import gnfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SLOTS = MAX_WIDTH * MAX_HEIGHT;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CX    = XW + FRAC_BITS;
   localparam int CY    = YW + FRAC_BITS;
   localparam int CXY   = (CX > CY) ? CX : CY;
   localparam int CW    = (CXY > WISH_W) ? CXY : WISH_W;
   localparam int DW    = 2 * CW + 1;
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN, ST_DRAIN, ST_COMMIT, ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [SW-1:0]         clr_addr_ff, clr_addr_in;
   logic                  scan_after_clear_ff, scan_after_clear_in;
   logic [CSR_DATA_W-1:0] width_ff, width_in;
   logic [CSR_DATA_W-1:0] height_ff, height_in;
   logic [XW-1:0]         wlast_ff, wlast_in, wlast_calc;
   logic [YW-1:0]         hlast_ff, hlast_in, hlast_calc;
   logic [XW-1:0]         x_ff, x_in;
   logic [YW-1:0]         y_ff, y_in;
   logic [SW-1:0]         j_ff, j_in;
   req_word_type          item_ff, item_in;
   logic                  p1_ff, p1_in;
   logic                  p2_ff, p2_in;
   logic [SW-1:0]         j1_ff, j1_in;
   logic [SW-1:0]         j2_ff, j2_in;
   logic                  taken2_ff, taken2_in;
   logic                  found_ff, found_in;
   logic [SW-1:0]         best_ff, best_in;
   logic [DW-1:0]         best_d_ff, best_d_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  ram_wr_en;
   logic [SW-1:0]         ram_wr_addr;
   logic [0:0]            ram_wr_data;
   logic [0:0]            ram_rd_data;
   logic [DW-1:0]         slot_dist;

   gnfp_ram #(
      .WIDTH(1),
      .DEPTH(SLOTS)
   ) u_taken_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(j_ff),
      .rd_data(ram_rd_data)
   );

   gnfp_dist #(
      .XW       (XW),
      .YW       (YW),
      .CW       (CW)
   ) u_dist (
      .clock  (clock),
      .wish_x (item_ff.wish_x),
      .wish_y (item_ff.wish_y),
      .x      (x_ff),
      .y      (y_ff),
      .sq_dist(slot_dist)
   );

   always_comb begin
      priority if (width_ff == '0) begin
         wlast_calc = '0;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         wlast_calc = XW'(MAX_WIDTH - 1);
      end else begin
         wlast_calc = XW'(32'(width_ff) - 32'd1);
      end
      priority if (height_ff == '0) begin
         hlast_calc = '0;
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         hlast_calc = YW'(MAX_HEIGHT - 1);
      end else begin
         hlast_calc = YW'(32'(height_ff) - 32'd1);
      end
   end

   always_comb begin
      state_in            = state_ff;
      clr_addr_in         = clr_addr_ff;
      scan_after_clear_in = scan_after_clear_ff;
      width_in            = width_ff;
      height_in           = height_ff;
      wlast_in            = wlast_ff;
      hlast_in            = hlast_ff;
      x_in                = x_ff;
      y_in                = y_ff;
      j_in                = j_ff;
      item_in             = item_ff;
      p1_in               = 1'b0;
      j1_in               = j_ff;
      p2_in               = p1_ff;
      j2_in               = j1_ff;
      taken2_in           = ram_rd_data[0];
      found_in            = found_ff;
      best_in             = best_ff;
      best_d_in           = best_d_ff;
      rsp_valid_in        = rsp_valid_ff;
      rsp_word_in         = rsp_word_ff;
      ram_wr_en           = 1'b0;
      ram_wr_addr         = clr_addr_ff;
      ram_wr_data         = 1'b0;

      if (p2_ff && !taken2_ff && (!found_ff || slot_dist < best_d_ff)) begin
         found_in  = 1'b1;
         best_in   = j2_ff;
         best_d_in = slot_dist;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default:          width_in  = width_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = 1'b0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_SLOT) begin
               state_in = scan_after_clear_ff ? ST_SCAN : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in             = req_word;
               x_in                = '0;
               y_in                = '0;
               j_in                = '0;
               found_in            = 1'b0;
               wlast_in            = wlast_calc;
               hlast_in            = hlast_calc;
               clr_addr_in         = '0;
               scan_after_clear_in = 1'b1;
               state_in            = req_word.start_image ? ST_CLEAR : ST_SCAN;
            end
         end
         ST_SCAN: begin
            p1_in = 1'b1;
            j_in  = j_ff + 1'b1;
            if (x_ff == wlast_ff) begin
               x_in = '0;
               y_in = y_ff + 1'b1;
            end else begin
               x_in = x_ff + 1'b1;
            end
            if (x_ff == wlast_ff && y_ff == hlast_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_ff && !p2_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (found_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = best_ff;
               ram_wr_data = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  rsp_word_in.placed     = 1'b1;
                  rsp_word_in.slot_index = SLOT_W'(best_ff);
                  rsp_word_in.red_out    = item_ff.red_in;
                  rsp_word_in.green_out  = item_ff.green_in;
                  rsp_word_in.blue_out   = item_ff.blue_in;
               end else begin
                  rsp_word_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_CLEAR;
         clr_addr_ff         <= '0;
         scan_after_clear_ff <= 1'b0;
         width_ff            <= IMAGE_WIDTH_RESET;
         height_ff           <= IMAGE_HEIGHT_RESET;
         p1_ff               <= 1'b0;
         p2_ff               <= 1'b0;
         found_ff            <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         clr_addr_ff         <= clr_addr_in;
         scan_after_clear_ff <= scan_after_clear_in;
         width_ff            <= width_in;
         height_ff           <= height_in;
         p1_ff               <= p1_in;
         p2_ff               <= p2_in;
         found_ff            <= found_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
      wlast_ff    <= wlast_in;
      hlast_ff    <= hlast_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      j_ff        <= j_in;
      item_ff     <= item_in;
      j1_ff       <= j1_in;
      j2_ff       <= j2_in;
      taken2_ff   <= taken2_in;
      best_ff     <= best_in;
      best_d_ff   <= best_d_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_SCAN || state_ff == ST_CLEAR)
      else $error("accepted word did not start a scan or clear");

   a_unplaced_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.placed |-> rsp_word.slot_index == '0 &&
         rsp_word.red_out == '0 && rsp_word.green_out == '0 &&
         rsp_word.blue_out == '0)
      else $error("unplaced word carries nonzero fields");

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      p2_ff |-> $past(p1_ff))
      else $error("distance pipeline stage two without stage one");

   a_commit_after_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |-> !p1_ff && !p2_ff)
      else $error("commit while slots still in flight");

endmodule

FILE: tb/sv/greedy_nearest_free_pixel_placer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the greedy nearest free pixel placer unit.
module greedy_nearest_free_pixel_placer_unit_tb;
   import gnfp_pkg::*;

   localparam int MAX_COLS     = MAX_WIDTH;
   localparam int MAX_ROWS     = MAX_HEIGHT;
   localparam int FRAC         = FRAC_BITS;
   localparam int WISH_MAX     = (1 << WISH_W) - 1;
   localparam int STALL_LIMIT  = 40000;
   localparam int PIXEL_TARGET = 140;

   class occupancy_board;
      bit                    taken [MAX_COLS*MAX_ROWS];
      logic [CSR_DATA_W-1:0] width_reg  = IMAGE_WIDTH_RESET;
      logic [CSR_DATA_W-1:0] height_reg = IMAGE_HEIGHT_RESET;
      rsp_word_type          expected_placements [$];
      int                    mismatch_count = 0;

      function int grid_cols();
         if (width_reg == 0) return 1;
         if (width_reg > MAX_COLS) return MAX_COLS;
         return int'(width_reg);
      endfunction

      function int grid_rows();
         if (height_reg == 0) return 1;
         if (height_reg > MAX_ROWS) return MAX_ROWS;
         return int'(height_reg);
      endfunction

      function int pending();
         return expected_placements.size();
      endfunction

      function void write_size(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_IMAGE_WIDTH) width_reg = value;
         else if (idx == CSR_IMAGE_HEIGHT) height_reg = value;
      endfunction

      function void place_pixel(req_word_type px);
         int           cols;
         int           total;
         int           best;
         longint       dx;
         longint       dy;
         longint       cand_dist;
         longint       best_dist;
         rsp_word_type res;
         cols      = grid_cols();
         total     = cols * grid_rows();
         best      = -1;
         best_dist = 0;
         res       = '0;
         if (px.start_image) begin
            foreach (taken[j]) taken[j] = 1'b0;
         end
         for (int j = 0; j < total; j++) begin
            if (!taken[j]) begin
               dx   = longint'(px.wish_x) - longint'(j % cols) * (longint'(1) << FRAC);
               dy   = longint'(px.wish_y) - longint'(j / cols) * (longint'(1) << FRAC);
               cand_dist = dx * dx + dy * dy;
               if (best < 0 || cand_dist < best_dist) begin
                  best      = j;
                  best_dist = cand_dist;
               end
            end
         end
         if (best >= 0) begin
            taken[best]    = 1'b1;
            res.placed     = 1'b1;
            res.slot_index = best[SLOT_W-1:0];
            res.red_out    = px.red_in;
            res.green_out  = px.green_in;
            res.blue_out   = px.blue_in;
         end
         expected_placements = {expected_placements, res};
      endfunction

      function void field_ok(string name, int unsigned want, int unsigned seen);
         if (want != seen) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
            mismatch_count++;
         end
      endfunction

      function void check_placement(rsp_word_type got);
         rsp_word_type want;
         if (expected_placements.size() == 0) begin
            $display("%0t: word with no pixel pending, expected none actual %h", $time, got);
            mismatch_count++;
            return;
         end
         want = expected_placements.pop_front();
         field_ok("placed", want.placed, got.placed);
         field_ok("slot_index", want.slot_index, got.slot_index);
         field_ok("red_out", want.red_out, got.red_out);
         field_ok("green_out", want.green_out, got.green_out);
         field_ok("blue_out", want.blue_out, got.blue_out);
      endfunction
   endclass

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   occupancy_board board = new();
   int idle_pct     = 9;
   int quiet_cycles = 0;
   int pixels_sent  = 0;

   greedy_nearest_free_pixel_placer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.place_pixel(req_word);
         if (rsp_valid && !rsp_stall) board.check_placement(rsp_word);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_word_type make_pixel(input bit start, input int unsigned wx,
                                               input int unsigned wy, input logic [23:0] rgb);
      req_word_type px;
      px.start_image = start;
      px.wish_x      = wx[WISH_W-1:0];
      px.wish_y      = wy[WISH_W-1:0];
      px.red_in      = rgb[23:16];
      px.green_in    = rgb[15:8];
      px.blue_in     = rgb[7:0];
      return px;
   endfunction

   function automatic int unsigned random_wish(input int span);
      case ($urandom_range(9))
         0: return $urandom_range(0, WISH_MAX);
         1: return $urandom_range(1) ? WISH_MAX : 0;
         default: return $urandom_range(0, span * (1 << FRAC) - 1);
      endcase
   endfunction

   task automatic send_pixel(input req_word_type px);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= px;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_size(input logic [CSR_DATA_W-1:0] cols, input logic [CSR_DATA_W-1:0] rows);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= cols;
      @(posedge clock);
      board.write_size(CSR_IMAGE_WIDTH, cols);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= rows;
      @(posedge clock);
      board.write_size(CSR_IMAGE_HEIGHT, rows);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int cols;
      int rows;
      int slots;
      int count;
      int phase;
      int k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_pixel(make_pixel(1'b1, 0, 0, 24'h000000));
      send_pixel(make_pixel(1'b0, 0, 0, 24'hFFFFFF));
      send_pixel(make_pixel(1'b0, WISH_MAX, WISH_MAX, 24'hFF00FF));
      send_pixel(make_pixel(1'b0, 16128, 16128, 24'h00FF00));
      send_pixel(make_pixel(1'b1, 14'h2AAA, 14'h1555, 24'hA5C3E1));
      send_pixel(make_pixel(1'b0, 14'h1555, 14'h2AAA, 24'h5A3C1E));
      drain();

      apply_size(7'd0, 7'd0);
      send_pixel(make_pixel(1'b1, 300, 700, 24'h123456));
      send_pixel(make_pixel(1'b0, 0, 0, 24'h654321));
      send_pixel(make_pixel(1'b0, WISH_MAX, 0, 24'hFFFFFF));
      drain();

      apply_size(7'd127, 7'd1);
      send_pixel(make_pixel(1'b0, 0, 0, 24'h0F0F0F));
      send_pixel(make_pixel(1'b0, WISH_MAX, 0, 24'hF0F0F0));
      send_pixel(make_pixel(1'b0, 0, 5000, 24'h3C3C3C));
      drain();

      apply_size(7'd1, 7'd64);
      send_pixel(make_pixel(1'b0, 0, WISH_MAX, 24'h818181));
      send_pixel(make_pixel(1'b0, 200, 8000, 24'h7E7E7E));
      send_pixel(make_pixel(1'b0, 0, 0, 24'hC0FFEE));
      drain();

      apply_size(7'd65, 7'd2);
      send_pixel(make_pixel(1'b1, 128, 128, 24'h010203));
      send_pixel(make_pixel(1'b0, 128, 128, 24'h040506));
      drain();

      apply_size(7'd2, 7'd2);
      send_pixel(make_pixel(1'b1, 384, 384, 24'h112233));
      for (k = 0; k < 4; k++) send_pixel(make_pixel(1'b0, 384, 384, 24'(24'h445566 + k)));

      phase = 0;
      while (pixels_sent < PIXEL_TARGET) begin
         drain();
         idle_pct = (phase == 2 || phase == 3) ? 0 : 9;
         if ($urandom_range(9) == 0) begin
            cols = $urandom_range(0, 127);
            rows = $urandom_range(0, 127);
         end else begin
            cols = $urandom_range(1, 8);
            rows = $urandom_range(1, 8);
         end
         apply_size(cols[CSR_DATA_W-1:0], rows[CSR_DATA_W-1:0]);
         slots = board.grid_cols() * board.grid_rows();
         count = (slots > 64) ? $urandom_range(1, 4) : $urandom_range(1, slots + 3);
         if (count > PIXEL_TARGET - pixels_sent) count = PIXEL_TARGET - pixels_sent;
         for (k = 0; k < count; k++) begin
            send_pixel(make_pixel((k == 0) ? ($urandom_range(4) != 0) : ($urandom_range(19) == 0),
                                  random_wish(board.grid_cols()),
                                  random_wish(board.grid_rows()),
                                  24'($urandom_range(0, 24'hFFFFFF))));
         end
         phase++;
      end
      drain();

      if (board.mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
